FILE: src/attestation_record_parser_core_assert.svh
// Assertion helpers for the attestation record parser.
// Each macro samples on clk_i and is quiet while rst_ni is low.
`ifndef ATTESTATION_RECORD_PARSER_CORE_ASSERT_SVH
`define ATTESTATION_RECORD_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define ARP_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`define ARP_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);
`else
`define ARP_ASSERT_IMPLY(label, pre, post, msg)
`define ARP_ASSERT_NEVER(label, expr, msg)
`endif

`endif

FILE: src/arp_pkg.sv
package arp_pkg;

  localparam int MAX_SELECTIONS   = 16;
  localparam int MAX_NAME_BYTES   = 128;
  localparam int MAX_EXTRA_BYTES  = 64;
  localparam int MAX_SELECT_BYTES = 4;
  localparam int MAX_DIGEST_BYTES = 64;

  localparam int BYTE_W    = 8;
  localparam int CODE_W    = 5;
  localparam int VALUE_W   = 64;
  localparam int SEL_IDX_W = 4;
  localparam int BIF_W     = 4;

  localparam int MAX_NE_BYTES = (MAX_NAME_BYTES > MAX_EXTRA_BYTES) ?
                                MAX_NAME_BYTES : MAX_EXTRA_BYTES;
  localparam int MAX_SD_BYTES = (MAX_SELECT_BYTES > MAX_DIGEST_BYTES) ?
                                MAX_SELECT_BYTES : MAX_DIGEST_BYTES;
  localparam int MAX_ARRAY_BYTES = (MAX_NE_BYTES > MAX_SD_BYTES) ? MAX_NE_BYTES : MAX_SD_BYTES;
  localparam int REM_W  = $clog2(MAX_ARRAY_BYTES + 1);
  localparam int SELS_W = $clog2(MAX_SELECTIONS + 1);

  localparam logic [CODE_W-1:0] PH_MAGIC       = 5'd0;
  localparam logic [CODE_W-1:0] PH_TYPE        = 5'd1;
  localparam logic [CODE_W-1:0] PH_NAME_SIZE   = 5'd2;
  localparam logic [CODE_W-1:0] PH_NAME_BYTE   = 5'd3;
  localparam logic [CODE_W-1:0] PH_EXTRA_SIZE  = 5'd4;
  localparam logic [CODE_W-1:0] PH_EXTRA_BYTE  = 5'd5;
  localparam logic [CODE_W-1:0] PH_CLOCK       = 5'd6;
  localparam logic [CODE_W-1:0] PH_RESET_CNT   = 5'd7;
  localparam logic [CODE_W-1:0] PH_RESTART_CNT = 5'd8;
  localparam logic [CODE_W-1:0] PH_SAFE        = 5'd9;
  localparam logic [CODE_W-1:0] PH_FW_VERSION  = 5'd10;
  localparam logic [CODE_W-1:0] PH_SEL_COUNT   = 5'd11;
  localparam logic [CODE_W-1:0] PH_HASH_ID     = 5'd12;
  localparam logic [CODE_W-1:0] PH_SEL_SIZE    = 5'd13;
  localparam logic [CODE_W-1:0] PH_SEL_BYTE    = 5'd14;
  localparam logic [CODE_W-1:0] PH_DIGEST_SIZE = 5'd15;
  localparam logic [CODE_W-1:0] PH_DIGEST_BYTE = 5'd16;
  localparam logic [CODE_W-1:0] PH_IDLE        = 5'd17;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              record_start;
  } arp_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]    field_code;
    logic [VALUE_W-1:0]   field_value;
    logic                 field_complete;
    logic [SEL_IDX_W-1:0] selection_index;
    logic                 record_complete;
    logic                 format_error;
  } arp_result_t;

  typedef struct packed {
    logic [CODE_W-1:0]    phase;
    logic [BIF_W-1:0]     byte_in_field;
    logic [REM_W-1:0]     bytes_remaining;
    logic [VALUE_W-1:0]   acc;
    logic [SELS_W-1:0]    sel_left;
    logic [SEL_IDX_W-1:0] sel_num;
    logic                 err;
  } arp_state_t;

  // Byte count of a fixed-size field; zero for byte-array fields.
  function automatic logic [BIF_W-1:0] fixed_len(logic [CODE_W-1:0] ph);
    logic [BIF_W-1:0] len;
    unique case (ph)
      PH_MAGIC, PH_RESET_CNT, PH_RESTART_CNT, PH_SEL_COUNT:  len = 4'd4;
      PH_TYPE, PH_NAME_SIZE, PH_EXTRA_SIZE, PH_HASH_ID,
      PH_DIGEST_SIZE:                                        len = 4'd2;
      PH_CLOCK, PH_FW_VERSION:                               len = 4'd8;
      PH_SAFE, PH_SEL_SIZE:                                  len = 4'd1;
      default:                                               len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: src/arp_if.sv
interface arp_in_if import arp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              record_start;

  modport source (output valid, output data_byte, output record_start, input ready);
  modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface arp_out_if import arp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CODE_W-1:0]    field_code;
  logic [VALUE_W-1:0]   field_value;
  logic                 field_complete;
  logic [SEL_IDX_W-1:0] selection_index;
  logic                 record_complete;
  logic                 format_error;

  modport source (output valid, output field_code, output field_value, output field_complete,
                  output selection_index, output record_complete, output format_error,
                  input ready);
  modport sink   (input valid, input field_code, input field_value, input field_complete,
                  input selection_index, input record_complete, input format_error,
                  output ready);
endinterface

FILE: src/arp_in_reg.sv
module arp_in_reg import arp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  arp_in_if.sink     in_i,
  input  logic       take_i,
  output logic       vld_o,
  output arp_item_t  item_o
);

  logic      vld_q;
  arp_item_t item_q;
  logic      load;

  assign in_i.ready = !vld_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data_byte    <= in_i.data_byte;
      item_q.record_start <= in_i.record_start;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

FILE: src/arp_parser.sv
module arp_parser import arp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  arp_item_t  item_i,
  output logic       take_o,
  arp_out_if.source  out_o
);

  arp_state_t  st_q, st_d, cur;
  arp_result_t res_q, res_d;
  logic        out_vld_q;

  logic [BIF_W-1:0]   len;
  logic [BIF_W-1:0]   bif_n;
  logic [REM_W-1:0]   rem_n;
  logic [VALUE_W-1:0] acc_n;
  logic [SELS_W-1:0]  left_n;
  logic               do_close;
  logic               do_fail;

  assign take_o = vld_i && (!out_vld_q || out_o.ready);

  always_comb begin
    cur = st_q;
    if (item_i.record_start) begin
      cur       = '0;
      cur.phase = PH_MAGIC;
    end

    st_d     = cur;
    res_d    = '0;
    do_close = 1'b0;
    do_fail  = 1'b0;
    len      = fixed_len(cur.phase);
    bif_n    = BIF_W'(cur.byte_in_field + 1'b1);
    rem_n    = REM_W'(cur.bytes_remaining - 1'b1);
    acc_n    = {cur.acc[VALUE_W-BYTE_W-1:0], item_i.data_byte};
    left_n   = SELS_W'(cur.sel_left - 1'b1);

    if (cur.err) begin
      res_d.format_error = 1'b1;
    end else if (cur.phase < PH_IDLE) begin
      res_d.field_code = cur.phase;
      if (cur.phase == PH_HASH_ID || cur.phase == PH_SEL_SIZE || cur.phase == PH_SEL_BYTE) begin
        res_d.selection_index = cur.sel_num;
      end
      if (len != '0) begin
        res_d.field_value = acc_n;
        if (bif_n >= len) begin
          res_d.field_complete = 1'b1;
          st_d.byte_in_field   = '0;
          st_d.acc             = '0;
          unique case (cur.phase)
            PH_NAME_SIZE: begin
              if (acc_n > VALUE_W'(MAX_NAME_BYTES)) begin
                do_fail = 1'b1;
              end else if (acc_n == '0) begin
                st_d.phase = PH_EXTRA_SIZE;
              end else begin
                st_d.bytes_remaining = acc_n[REM_W-1:0];
                st_d.phase           = PH_NAME_BYTE;
              end
            end
            PH_EXTRA_SIZE: begin
              if (acc_n > VALUE_W'(MAX_EXTRA_BYTES)) begin
                do_fail = 1'b1;
              end else if (acc_n == '0) begin
                st_d.phase = PH_CLOCK;
              end else begin
                st_d.bytes_remaining = acc_n[REM_W-1:0];
                st_d.phase           = PH_EXTRA_BYTE;
              end
            end
            PH_SEL_COUNT: begin
              if (acc_n > VALUE_W'(MAX_SELECTIONS)) begin
                do_fail = 1'b1;
              end else if (acc_n == '0) begin
                st_d.phase = PH_DIGEST_SIZE;
              end else begin
                st_d.sel_left = acc_n[SELS_W-1:0];
                st_d.sel_num  = '0;
                st_d.phase    = PH_HASH_ID;
              end
            end
            PH_SEL_SIZE: begin
              if (acc_n > VALUE_W'(MAX_SELECT_BYTES)) begin
                do_fail = 1'b1;
              end else if (acc_n == '0) begin
                do_close = 1'b1;
              end else begin
                st_d.bytes_remaining = acc_n[REM_W-1:0];
                st_d.phase           = PH_SEL_BYTE;
              end
            end
            PH_DIGEST_SIZE: begin
              if (acc_n > VALUE_W'(MAX_DIGEST_BYTES)) begin
                do_fail = 1'b1;
              end else if (acc_n == '0) begin
                res_d.record_complete = 1'b1;
                st_d.phase            = PH_IDLE;
              end else begin
                st_d.bytes_remaining = acc_n[REM_W-1:0];
                st_d.phase           = PH_DIGEST_BYTE;
              end
            end
            default: st_d.phase = CODE_W'(cur.phase + 1'b1);
          endcase
        end else begin
          st_d.byte_in_field = bif_n;
          st_d.acc           = acc_n;
        end
      end else begin
        res_d.field_value    = VALUE_W'(item_i.data_byte);
        st_d.bytes_remaining = rem_n;
        if (rem_n == '0) begin
          res_d.field_complete = 1'b1;
          unique case (cur.phase)
            PH_NAME_BYTE:  st_d.phase = PH_EXTRA_SIZE;
            PH_EXTRA_BYTE: st_d.phase = PH_CLOCK;
            PH_SEL_BYTE:   do_close   = 1'b1;
            default: begin
              res_d.record_complete = 1'b1;
              st_d.phase            = PH_IDLE;
            end
          endcase
        end
      end

      // Retire one selection entry: next entry or on to the digest.
      if (do_close) begin
        st_d.sel_left = left_n;
        if (left_n == '0) begin
          st_d.phase = PH_DIGEST_SIZE;
        end else begin
          st_d.sel_num = SEL_IDX_W'(cur.sel_num + 1'b1);
          st_d.phase   = PH_HASH_ID;
        end
      end

      // Latch the error and drop bytes until the next record start.
      if (do_fail) begin
        res_d.format_error = 1'b1;
        st_d.err           = 1'b1;
        st_d.phase         = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '{phase: PH_MAGIC, default: '0};
      out_vld_q <= 1'b0;
    end else begin
      if (take_o) begin
        st_q <= st_d;
      end
      if (take_o) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.field_code      = res_q.field_code;
  assign out_o.field_value     = res_q.field_value;
  assign out_o.field_complete  = res_q.field_complete;
  assign out_o.selection_index = res_q.selection_index;
  assign out_o.record_complete = res_q.record_complete;
  assign out_o.format_error    = res_q.format_error;

endmodule

FILE: src/attestation_record_parser_core.sv
// Streaming parser for a big-endian quote attestation record.
// Input channel in_i carries one record byte per transfer plus record_start,
// which restarts the parser on the first magic byte of a new record.
// Output channel out_o carries one result per input byte: the field code,
// the big-endian value gathered so far (raw byte in array fields), the
// field and record end flags, the selection index and format_error.
// A length or count above its bound reports format_error on the last byte
// of that field; later bytes up to the next record_start come out with only format_error set.
// Each result passes through the input register and then the result
// register before it is valid on out_o.
// Throughput: one byte per cycle while out_o.ready stays high; the parse
// state update is a single registered step per byte.
// Reset: both stages empty, parser expects the magic field.
// When the receiver stalls, the result register holds and the input
// register still takes one byte; after that in_i.ready drops until the
// result is taken.
`include "attestation_record_parser_core_assert.svh"

module attestation_record_parser_core import arp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  arp_in_if.sink    in_i,
  arp_out_if.source out_o
);

  logic      item_vld;
  arp_item_t item;
  logic      take;

  arp_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (take),
    .vld_o  (item_vld),
    .item_o (item)
  );

  arp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (item_vld),
    .item_i (item),
    .take_o (take),
    .out_o  (out_o)
  );

  `ARP_ASSERT_IMPLY(a_rec_end_on_digest, out_o.valid && out_o.record_complete,
    out_o.field_complete && !out_o.format_error &&
    (out_o.field_code == PH_DIGEST_SIZE || out_o.field_code == PH_DIGEST_BYTE),
    "record end outside the digest")
  `ARP_ASSERT_IMPLY(a_sel_idx_scope, out_o.valid && out_o.selection_index != '0,
    out_o.field_code == PH_HASH_ID || out_o.field_code == PH_SEL_SIZE ||
    out_o.field_code == PH_SEL_BYTE,
    "selection index outside a selection")
  `ARP_ASSERT_IMPLY(a_err_drop_clean, out_o.valid && out_o.format_error && !out_o.field_complete,
    out_o.field_code == PH_MAGIC && out_o.field_value == '0,
    "dropped byte after error carries data")
  `ARP_ASSERT_NEVER(a_code_range, out_o.valid && out_o.field_code > PH_DIGEST_BYTE,
    "field code out of range")

endmodule

FILE: test/tb.sv
module tb;
  import arp_pkg::*;

  localparam int ITEM_GOAL    = 650;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Tracks the parser state byte by byte and holds the results still owed.
  class parse_result_checker;
    logic [CODE_W-1:0]    phase     = PH_MAGIC;
    int unsigned          byte_pos  = 0;
    logic [15:0]          bytes_left = '0;
    logic [VALUE_W-1:0]   acc       = '0;
    logic [4:0]           sel_left  = '0;
    logic [SEL_IDX_W-1:0] sel_num   = '0;
    bit                   err_latched = 1'b0;
    bit                   rec_end;
    bit                   fmt_flag;
    arp_result_t          awaited_results[$];
    int unsigned          mismatches = 0;

    function void clear_state();
      phase       = PH_MAGIC;
      byte_pos    = 0;
      bytes_left  = '0;
      acc         = '0;
      sel_left    = '0;
      sel_num     = '0;
      err_latched = 1'b0;
    endfunction

    function int unsigned field_bytes(logic [CODE_W-1:0] ph);
      case (ph)
        PH_MAGIC:       return 4;
        PH_TYPE:        return 2;
        PH_NAME_SIZE:   return 2;
        PH_EXTRA_SIZE:  return 2;
        PH_CLOCK:       return 8;
        PH_RESET_CNT:   return 4;
        PH_RESTART_CNT: return 4;
        PH_SAFE:        return 1;
        PH_FW_VERSION:  return 8;
        PH_SEL_COUNT:   return 4;
        PH_HASH_ID:     return 2;
        PH_SEL_SIZE:    return 1;
        PH_DIGEST_SIZE: return 2;
        default:        return 0;
      endcase
    endfunction

    function void flag_bound();
      fmt_flag    = 1'b1;
      err_latched = 1'b1;
      phase       = PH_IDLE;
    endfunction

    function void close_selection();
      sel_left = sel_left - 1'b1;
      if (sel_left == 0) begin
        phase = PH_DIGEST_SIZE;
      end else begin
        sel_num = sel_num + 1'b1;
        phase   = PH_HASH_ID;
      end
    endfunction

    // Enter the array phase, or skip it when the size is zero.
    function void open_array(logic [VALUE_W-1:0] n, logic [CODE_W-1:0] arr,
                             logic [CODE_W-1:0] nxt);
      if (n == 0) begin
        phase = nxt;
      end else begin
        bytes_left = n[15:0];
        phase      = arr;
      end
    endfunction

    function void close_fixed(logic [CODE_W-1:0] ph, logic [VALUE_W-1:0] v);
      case (ph)
        PH_NAME_SIZE: begin
          if (v > MAX_NAME_BYTES) flag_bound();
          else open_array(v, PH_NAME_BYTE, PH_EXTRA_SIZE);
        end
        PH_EXTRA_SIZE: begin
          if (v > MAX_EXTRA_BYTES) flag_bound();
          else open_array(v, PH_EXTRA_BYTE, PH_CLOCK);
        end
        PH_SEL_COUNT: begin
          if (v > MAX_SELECTIONS) begin
            flag_bound();
          end else if (v == 0) begin
            phase = PH_DIGEST_SIZE;
          end else begin
            sel_left = v[4:0];
            sel_num  = '0;
            phase    = PH_HASH_ID;
          end
        end
        PH_SEL_SIZE: begin
          if (v > MAX_SELECT_BYTES) flag_bound();
          else if (v == 0) close_selection();
          else open_array(v, PH_SEL_BYTE, PH_SEL_BYTE);
        end
        PH_DIGEST_SIZE: begin
          if (v > MAX_DIGEST_BYTES) begin
            flag_bound();
          end else if (v == 0) begin
            rec_end = 1'b1;
            phase   = PH_IDLE;
          end else begin
            open_array(v, PH_DIGEST_BYTE, PH_DIGEST_BYTE);
          end
        end
        default: phase = ph + 1'b1;
      endcase
    endfunction

    function void close_array(logic [CODE_W-1:0] ph);
      if (ph == PH_NAME_BYTE) begin
        phase = PH_EXTRA_SIZE;
      end else if (ph == PH_EXTRA_BYTE) begin
        phase = PH_CLOCK;
      end else if (ph == PH_SEL_BYTE) begin
        close_selection();
      end else begin
        rec_end = 1'b1;
        phase   = PH_IDLE;
      end
    endfunction

    function void absorb_byte(arp_item_t it);
      arp_result_t        r;
      logic [CODE_W-1:0]  ph;
      logic [VALUE_W-1:0] v;
      bit                 done_fld;
      int unsigned        flen;
      if (it.record_start) clear_state();
      r = '0;
      r.format_error = err_latched;
      if (!err_latched && phase < PH_IDLE) begin
        rec_end  = 1'b0;
        fmt_flag = 1'b0;
        done_fld = 1'b0;
        ph       = phase;
        r.selection_index = (ph >= PH_HASH_ID && ph <= PH_SEL_BYTE) ? sel_num : '0;
        flen = field_bytes(ph);
        if (flen != 0) begin
          acc      = {acc[VALUE_W-9:0], it.data_byte};
          v        = acc;
          byte_pos = byte_pos + 1;
          if (byte_pos >= flen) begin
            done_fld = 1'b1;
            byte_pos = 0;
            acc      = '0;
            close_fixed(ph, v);
          end
        end else begin
          v          = {56'h0, it.data_byte};
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == 0) begin
            done_fld = 1'b1;
            close_array(ph);
          end
        end
        r.field_code      = ph;
        r.field_value     = v;
        r.field_complete  = done_fld;
        r.record_complete = rec_end;
        r.format_error    = fmt_flag;
      end
      awaited_results.push_back(r);
    endfunction

    function void check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void compare_result(arp_result_t got);
      arp_result_t want;
      if (awaited_results.size() == 0) begin
        $error("field_code: expected no result, got %h", got.field_code);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      check_field("field_code", want.field_code, got.field_code);
      check_field("field_value", want.field_value, got.field_value);
      check_field("field_complete", want.field_complete, got.field_complete);
      check_field("selection_index", want.selection_index, got.selection_index);
      check_field("record_complete", want.record_complete, got.record_complete);
      check_field("format_error", want.format_error, got.format_error);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  arp_in_if  in_if ();
  arp_out_if out_if ();

  attestation_record_parser_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  parse_result_checker chk;
  arp_item_t           record_bytes[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_byte(logic [7:0] b, logic start);
    arp_item_t it;
    it.data_byte    = b;
    it.record_start = start;
    record_bytes.push_back(it);
  endfunction

  // Append a fixed field most significant byte first.
  function automatic void push_field(logic [63:0] v, int n);
    for (int k = n - 1; k >= 0; k--) push_byte(v[8*k +: 8], 1'b0);
  endfunction

  function automatic void push_random(int n);
    for (int k = 0; k < n; k++) push_byte($urandom_range(0, 255), 1'b0);
  endfunction

  function automatic logic [63:0] pick_len(int bound);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return $urandom_range(0, 3);
    if (roll < 15) return bound;
    return $urandom_range(0, bound);
  endfunction

  function automatic logic [63:0] over_bound(int bound, int unsigned top);
    if ($urandom_range(0, 1) == 0) return bound + 1;
    return $urandom_range(top, bound + 1);
  endfunction

  // Cut, pad with stray bytes and mark the first byte of the record.
  function automatic void finish_record(int start_pos);
    int end_pos;
    int cut;
    end_pos = record_bytes.size();
    if ($urandom_range(0, 9) == 0 && end_pos - start_pos > 1) begin
      cut = $urandom_range(start_pos + 1, end_pos - 1);
      while (record_bytes.size() > cut) void'(record_bytes.pop_back());
    end
    if ($urandom_range(0, 1) == 0) push_random($urandom_range(1, 4));
    if ($urandom_range(0, 7) == 0) begin
      for (int k = $urandom_range(2, 8); k > 0; k--) begin
        push_byte($urandom_range(0, 255), $urandom_range(0, 3) == 0);
      end
    end
    record_bytes[start_pos].record_start = 1'b1;
  endfunction

  function automatic void build_record();
    int          start_pos;
    int          broken;
    int          sel_cnt;
    int          bad_sel;
    int          roll;
    logic [63:0] len;
    start_pos = record_bytes.size();
    broken    = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
    push_field($urandom, 4);
    push_field($urandom, 2);

    len = (broken == 1) ? over_bound(MAX_NAME_BYTES, 16'hFFFF) : pick_len(MAX_NAME_BYTES);
    push_field(len, 2);
    if (broken == 1) begin
      finish_record(start_pos);
      return;
    end
    push_random(int'(len));

    len = (broken == 2) ? over_bound(MAX_EXTRA_BYTES, 16'hFFFF) : pick_len(MAX_EXTRA_BYTES);
    push_field(len, 2);
    if (broken == 2) begin
      finish_record(start_pos);
      return;
    end
    push_random(int'(len));

    push_field({$urandom, $urandom}, 8);
    push_field($urandom, 4);
    push_field($urandom, 4);
    push_field($urandom, 1);
    push_field({$urandom, $urandom}, 8);

    if (broken == 3) begin
      len = over_bound(MAX_SELECTIONS, 32'hFFFF_FFFF);
    end else begin
      roll = $urandom_range(0, 9);
      if (roll < 7) len = $urandom_range(0, 3);
      else if (roll == 7) len = MAX_SELECTIONS;
      else len = $urandom_range(0, MAX_SELECTIONS);
    end
    push_field(len, 4);
    if (broken == 3) begin
      finish_record(start_pos);
      return;
    end
    sel_cnt = int'(len);
    bad_sel = (broken == 4 && sel_cnt > 0) ? $urandom_range(0, sel_cnt - 1) : -1;
    for (int s = 0; s < sel_cnt; s++) begin
      push_field($urandom, 2);
      len = (s == bad_sel) ? over_bound(MAX_SELECT_BYTES, 255) :
            $urandom_range(0, MAX_SELECT_BYTES);
      push_field(len, 1);
      if (s == bad_sel) begin
        finish_record(start_pos);
        return;
      end
      push_random(int'(len));
    end

    len = (broken == 5) ? over_bound(MAX_DIGEST_BYTES, 16'hFFFF) : pick_len(MAX_DIGEST_BYTES);
    push_field(len, 2);
    if (broken != 5) push_random(int'(len));
    finish_record(start_pos);
  endfunction

  function automatic void build_directed();
    int start_pos;
    // parsed as magic without a record start, then an oversized signer name
    push_field(32'hFFFF_FFFF, 4);
    push_field(16'hFFFF, 2);
    push_field(16'hFFFF, 2);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b0);
    // empty signer name, extra size one above its bound
    start_pos = record_bytes.size();
    push_field(32'h0, 4);
    push_field(16'h0, 2);
    push_field(16'h0, 2);
    push_field(MAX_EXTRA_BYTES + 1, 2);
    record_bytes[start_pos].record_start = 1'b1;
    push_byte(8'h5A, 1'b0);
    // restart cut short by the next record
    push_byte(8'h12, 1'b1);
    push_byte(8'h34, 1'b0);
  endfunction

  // Idle draw with occasional stretches of back-to-back transfers.
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(15, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic drive_bytes();
    int calm;
    int gap;
    calm = 0;
    for (int i = 0; i < record_bytes.size(); i++) begin
      gap = draw_wait(calm);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_if.valid        <= 1'b1;
      in_if.data_byte    <= record_bytes[i].data_byte;
      in_if.record_start <= record_bytes[i].record_start;
      do @(posedge clk); while (!in_if.ready);
      chk.absorb_byte(record_bytes[i]);
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int          calm;
    int          gap;
    arp_result_t got;
    calm = 0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_wait(calm);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.field_code      = out_if.field_code;
      got.field_value     = out_if.field_value;
      got.field_complete  = out_if.field_complete;
      got.selection_index = out_if.selection_index;
      got.record_complete = out_if.record_complete;
      got.format_error    = out_if.format_error;
      chk.compare_result(got);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("[attestation_record_parser_core] ERROR");
    $finish;
  end

  initial begin : main_flow
    int goal;
    chk = new();
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.data_byte    <= '0;
    in_if.record_start <= 1'b0;
    build_directed();
    goal = record_bytes.size() + ITEM_GOAL;
    while (record_bytes.size() < goal) build_record();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    drive_bytes();
    while (chk.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.mismatches == 0 && chk.awaited_results.size() == 0) begin
      $display("[attestation_record_parser_core] OK");
    end else begin
      $display("[attestation_record_parser_core] ERROR");
    end
    $finish;
  end

endmodule
